// ----- rtl/pdsvn_pkg.sv -----
// Package for the USB-PD sink voltage negotiator.
// Holds word types, state and opcode codes, register indexes and level helpers.
// No dependencies.
package pdsvn_pkg;

  localparam int VOLT_W      = 5;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int LEVEL_COUNT = 5;
  localparam int TRY_W       = 3;

  localparam logic [VOLT_W-1:0] DEFAULT_LEVEL   = 5'd12;
  localparam logic [CFG_W-1:0]  TIMEOUT_RESET   = 16'd3000;
  localparam logic [CFG_W-1:0]  DEBOUNCE_RESET  = 16'd100;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POWER_ON = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_NEG  = 3'd1,
    MODE_AUTO = 3'd2,
    MODE_OK   = 3'd3,
    MODE_FAIL = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    OP_TICK = 2'd0,
    OP_SET  = 2'd1,
    OP_AUTO = 2'd2
  } opcode_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [VOLT_W-1:0] requested_volts;
    logic              pg_pin_low;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        negotiation_state;
    logic [VOLT_W-1:0] target_volts;
    logic [VOLT_W-1:0] negotiated_volts;
    logic              cfg_pin_one;
    logic              cfg_pin_two;
    logic              cfg_pin_three;
    logic              power_good;
    logic              bad_request;
    logic              save_pulse;
  } out_word_t;

  // Control from the negotiation logic to the power-good filter
  typedef struct packed {
    logic start;   // attempt started by a command: clear filter before the tick
    logic retry;   // auto step-down: clear filter after the tick
  } pg_ctl_t;

  // Restart request from a power-on voltage write
  typedef struct packed {
    logic              valid;
    logic [VOLT_W-1:0] level;
  } restart_t;

  function automatic logic level_ok(input logic [VOLT_W-1:0] v);
    return (v == 5'd5) || (v == 5'd9) || (v == 5'd12) || (v == 5'd15) || (v == 5'd20);
  endfunction

  // Auto step-down order: 20, 15, 12, 9, 5 V
  function automatic logic [VOLT_W-1:0] step_level(input logic [TRY_W-1:0] idx);
    logic [VOLT_W-1:0] v;
    v = 5'd5;
    case (idx)
      3'd0:    v = 5'd20;
      3'd1:    v = 5'd15;
      3'd2:    v = 5'd12;
      3'd3:    v = 5'd9;
      default: v = 5'd5;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/pdsvn_debounce.sv -----
// Power-good filter: remembers the last raw level and counts stable ticks.
// Depends on pdsvn_pkg.
module pdsvn_debounce #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  logic                        raw_i,
  input  pdsvn_pkg::pg_ctl_t          ctl_i,
  input  logic                        clear_i,
  input  logic [pdsvn_pkg::CFG_W-1:0] debounce_ticks_i,
  output logic                        pg_o
);

  localparam int CMP_W = (TIMER_BITS > pdsvn_pkg::CFG_W) ? TIMER_BITS : pdsvn_pkg::CFG_W;

  logic [TIMER_BITS-1:0] stable_q, stable_d, stable_n;
  logic                  last_q, last_d, last_n;
  logic                  deb_q, deb_d, deb_n;

  // Tick update: optional clear, saturating count, level change, accept
  always_comb begin
    stable_n = stable_q;
    last_n   = last_q;
    deb_n    = deb_q;
    if (ctl_i.start) begin
      stable_n = '0;
      last_n   = 1'b0;
      deb_n    = 1'b0;
    end else if (stable_q != {TIMER_BITS{1'b1}}) begin
      stable_n = stable_q + 1'b1;
    end
    if (raw_i != last_n) begin
      stable_n = '0;
      last_n   = raw_i;
    end
    if (CMP_W'(stable_n) >= CMP_W'(debounce_ticks_i)) begin
      deb_n = raw_i;
    end
  end

  assign pg_o = deb_n;

  // Next state
  always_comb begin
    stable_d = stable_q;
    last_d   = last_q;
    deb_d    = deb_q;
    if (clear_i) begin
      stable_d = '0;
      last_d   = 1'b0;
      deb_d    = 1'b0;
    end else if (step_i) begin
      if (ctl_i.retry) begin
        stable_d = '0;
        last_d   = 1'b0;
        deb_d    = 1'b0;
      end else begin
        stable_d = stable_n;
        last_d   = last_n;
        deb_d    = deb_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q <= '0;
      last_q   <= 1'b0;
      deb_q    <= 1'b0;
    end else begin
      stable_q <= stable_d;
      last_q   <= last_d;
      deb_q    <= deb_d;
    end
  end

endmodule

// ----- rtl/pdsvn_ctrl.sv -----
// Negotiation control: mode, target and reached levels, attempt timer, auto step-down.
// Depends on pdsvn_pkg; takes the filtered power-good from pdsvn_debounce.
module pdsvn_ctrl #(
  parameter int TIMER_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        step_i,
  input  pdsvn_pkg::in_word_t         word_i,
  input  logic [pdsvn_pkg::CFG_W-1:0] timeout_i,
  input  logic                        pg_i,
  input  pdsvn_pkg::restart_t         restart_i,
  output pdsvn_pkg::pg_ctl_t          pg_ctl_o,
  output pdsvn_pkg::out_word_t        result_o
);

  localparam int CMP_W = (TIMER_BITS > pdsvn_pkg::CFG_W) ? TIMER_BITS : pdsvn_pkg::CFG_W;

  pdsvn_pkg::mode_e                 mode_q, mode_d, mode_n;
  logic [pdsvn_pkg::VOLT_W-1:0]     target_q, target_d, target_n;
  logic [pdsvn_pkg::VOLT_W-1:0]     reached_q, reached_d, reached_n;
  logic [pdsvn_pkg::TRY_W-1:0]      try_q, try_d, try_n, try_inc;
  logic [TIMER_BITS-1:0]            elapsed_q, elapsed_d, elapsed_n;
  logic                             start, retry, bad, save;

  // Command, timer and state machine for one tick
  always_comb begin
    mode_n    = mode_q;
    target_n  = target_q;
    reached_n = reached_q;
    try_n     = try_q;
    elapsed_n = elapsed_q;
    start     = 1'b0;
    retry     = 1'b0;
    bad       = 1'b0;
    save      = 1'b0;

    case (word_i.opcode)
      pdsvn_pkg::OP_SET: begin
        if (pdsvn_pkg::level_ok(word_i.requested_volts)) begin
          start     = 1'b1;
          mode_n    = pdsvn_pkg::MODE_NEG;
          target_n  = word_i.requested_volts;
          reached_n = '0;
          elapsed_n = '0;
        end else begin
          bad = 1'b1;
        end
      end
      pdsvn_pkg::OP_AUTO: begin
        start     = 1'b1;
        try_n     = '0;
        mode_n    = pdsvn_pkg::MODE_AUTO;
        target_n  = pdsvn_pkg::step_level('0);
        reached_n = '0;
        elapsed_n = '0;
      end
      default: ;
    endcase

    // Attempt timer saturates
    if (!start && (elapsed_q != {TIMER_BITS{1'b1}})) begin
      elapsed_n = elapsed_q + 1'b1;
    end

    try_inc = try_n + 1'b1;
    if ((mode_n == pdsvn_pkg::MODE_NEG) || (mode_n == pdsvn_pkg::MODE_AUTO)) begin
      if (pg_i) begin
        mode_n    = pdsvn_pkg::MODE_OK;
        reached_n = target_n;
        save      = 1'b1;
      end else if (CMP_W'(elapsed_n) >= CMP_W'(timeout_i)) begin
        if (mode_n == pdsvn_pkg::MODE_NEG) begin
          mode_n    = pdsvn_pkg::MODE_FAIL;
          reached_n = '0;
        end else begin
          try_n = try_inc;
          if (try_inc >= pdsvn_pkg::TRY_W'(pdsvn_pkg::LEVEL_COUNT)) begin
            mode_n    = pdsvn_pkg::MODE_FAIL;
            reached_n = '0;
          end else begin
            retry     = 1'b1;
            target_n  = pdsvn_pkg::step_level(try_inc);
            reached_n = '0;
            elapsed_n = '0;
          end
        end
      end
    end
  end

  assign pg_ctl_o.start = start;
  assign pg_ctl_o.retry = retry;

  // Result word; config pins encode the target level
  always_comb begin
    result_o.negotiation_state = mode_n;
    result_o.target_volts      = target_n;
    result_o.negotiated_volts  = reached_n;
    result_o.cfg_pin_one       = (target_n == 5'd5);
    result_o.cfg_pin_two       = (target_n == 5'd15) || (target_n == 5'd20);
    result_o.cfg_pin_three     = (target_n == 5'd12) || (target_n == 5'd15);
    result_o.power_good        = pg_i;
    result_o.bad_request       = bad;
    result_o.save_pulse        = save;
  end

  // Next state: restart from a power-on write, else commit the tick
  always_comb begin
    mode_d    = mode_q;
    target_d  = target_q;
    reached_d = reached_q;
    try_d     = try_q;
    elapsed_d = elapsed_q;
    if (restart_i.valid) begin
      mode_d    = pdsvn_pkg::MODE_NEG;
      target_d  = restart_i.level;
      reached_d = '0;
      try_d     = '0;
      elapsed_d = '0;
    end else if (step_i) begin
      mode_d    = mode_n;
      target_d  = target_n;
      reached_d = reached_n;
      try_d     = try_n;
      elapsed_d = elapsed_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= pdsvn_pkg::MODE_NEG;
      target_q  <= pdsvn_pkg::DEFAULT_LEVEL;
      reached_q <= '0;
      try_q     <= '0;
      elapsed_q <= '0;
    end else begin
      mode_q    <= mode_d;
      target_q  <= target_d;
      reached_q <= reached_d;
      try_q     <= try_d;
      elapsed_q <= elapsed_d;
    end
  end

`ifndef ASSERT_OFF
  a_ok_reached : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pdsvn_pkg::MODE_OK) |-> (reached_q == target_q))
    else $error("reached level differs from target in success state");

  a_reached_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q != pdsvn_pkg::MODE_OK) |-> (reached_q == '0))
    else $error("reached level nonzero outside success state");

  a_try_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    try_q <= pdsvn_pkg::TRY_W'(pdsvn_pkg::LEVEL_COUNT))
    else $error("step-down index past end of level list");

  a_auto_level : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == pdsvn_pkg::MODE_AUTO) |->
      ((try_q < pdsvn_pkg::TRY_W'(pdsvn_pkg::LEVEL_COUNT)) &&
       (target_q == pdsvn_pkg::step_level(try_q))))
    else $error("auto target does not match step-down index");

  a_save_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && save) |=> (mode_q == pdsvn_pkg::MODE_OK))
    else $error("save pulse without entering success state");
`endif

endmodule

// ----- rtl/pd_sink_voltage_negotiator.sv -----
// Throughput: one word per cycle while the result register is free or being read;
// the tick update is a single pass from the input register through the negotiation
// and filter logic to the result register.
// Reset: 12 V single negotiation, timeout 3000, debounce 100, no word held.
// Depends on pdsvn_pkg, pdsvn_debounce and pdsvn_ctrl.
module pd_sink_voltage_negotiator #(
  parameter int TIMER_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  pdsvn_pkg::in_word_t             in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output pdsvn_pkg::out_word_t            out_data_o,
  input  logic                            cfg_we_i,
  input  logic [pdsvn_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pdsvn_pkg::CFG_W-1:0]     cfg_wdata_i
);

  logic                            in_valid_q;
  pdsvn_pkg::in_word_t             in_q;
  logic                            out_valid_q;
  pdsvn_pkg::out_word_t            out_q;
  logic                            step;
  logic [pdsvn_pkg::CFG_W-1:0]     timeout_q, timeout_d;
  logic [pdsvn_pkg::CFG_W-1:0]     debounce_q, debounce_d;
  pdsvn_pkg::restart_t             restart;
  pdsvn_pkg::pg_ctl_t              pg_ctl;
  pdsvn_pkg::out_word_t            result;
  logic                            pg_now;
  logic [pdsvn_pkg::VOLT_W-1:0]    pon_level;

  // Handshake: the held word advances when the result register is free or being read
  assign step        = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || step;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Configuration decode
  assign pon_level = cfg_wdata_i[pdsvn_pkg::VOLT_W-1:0];
  always_comb begin
    timeout_d     = timeout_q;
    debounce_d    = debounce_q;
    restart.valid = 1'b0;
    restart.level = pdsvn_pkg::level_ok(pon_level) ? pon_level : pdsvn_pkg::DEFAULT_LEVEL;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        pdsvn_pkg::CFG_TIMEOUT:  timeout_d     = cfg_wdata_i;
        pdsvn_pkg::CFG_DEBOUNCE: debounce_d    = cfg_wdata_i;
        pdsvn_pkg::CFG_POWER_ON: restart.valid = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q  <= pdsvn_pkg::TIMEOUT_RESET;
      debounce_q <= pdsvn_pkg::DEBOUNCE_RESET;
    end else begin
      timeout_q  <= timeout_d;
      debounce_q <= debounce_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  pdsvn_debounce #(
    .TIMER_BITS(TIMER_BITS)
  ) u_debounce (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .step_i          (step),
    .raw_i           (in_q.pg_pin_low),
    .ctl_i           (pg_ctl),
    .clear_i         (restart.valid),
    .debounce_ticks_i(debounce_q),
    .pg_o            (pg_now)
  );

  pdsvn_ctrl #(
    .TIMER_BITS(TIMER_BITS)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_q),
    .timeout_i(timeout_q),
    .pg_i     (pg_now),
    .restart_i(restart),
    .pg_ctl_o (pg_ctl),
    .result_o (result)
  );

endmodule

// ----- test/tb_pd_sink_voltage_negotiator.sv -----
// Self-checking testbench for the USB-PD sink voltage negotiator.
// A queue-fed driver, a result monitor and a tick-level predictor of the negotiator.
// Depends on pdsvn_pkg and pd_sink_voltage_negotiator.
`timescale 1ns / 100ps

module tb_pd_sink_voltage_negotiator;

  localparam int          CYCLE_LIMIT = 1_000_000;
  localparam int          HOLD_CYCLES = 80;
  localparam logic [15:0] TMR_MAX     = 16'hFFFF;
  localparam logic [1:0]  OP_SPARE    = 2'd3;   // unused opcode, acts as a plain tick
  // Auto step-down order, lowest slice first: 20, 15, 12, 9, 5 V
  localparam logic [24:0] STEP_DOWN   = {5'd5, 5'd9, 5'd12, 5'd15, 5'd20};

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_ready_o;
  pdsvn_pkg::in_word_t  in_data_i   = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  pdsvn_pkg::out_word_t out_data_o;
  logic                 cfg_we_i    = 1'b0;
  logic [pdsvn_pkg::CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [pdsvn_pkg::CFG_W-1:0]     cfg_wdata_i = '0;

  pdsvn_pkg::in_word_t  tick_q[$];             // words waiting to be sent
  pdsvn_pkg::out_word_t expected_status_q[$];  // predicted status words in order

  int unsigned snd_idle_pct  = 0;
  int unsigned rcv_idle_pct  = 0;
  int unsigned hold_requests = 0;   // bumped by stimulus
  int unsigned hold_served   = 0;   // owned by the monitor
  int unsigned hold_left     = 0;
  int unsigned err_count     = 0;
  int unsigned cycle_count   = 0;

  // Predictor state and register copies
  pdsvn_pkg::mode_e p_mode;
  logic [4:0]       p_target;
  logic [4:0]       p_reached;
  logic [2:0]       p_try;
  logic [15:0]      p_attempt;
  logic             p_pg_good;
  logic             p_pg_raw;
  logic [15:0]      p_pg_stable;
  logic [15:0]      r_timeout;
  logic [15:0]      r_debounce;
  logic [4:0]       r_power_on;

  pd_sink_voltage_negotiator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic is_pd_level(input logic [4:0] v);
    return v == 5'd5 || v == 5'd9 || v == 5'd12 || v == 5'd15 || v == 5'd20;
  endfunction

  function automatic logic [15:0] sat_inc16(input logic [15:0] t);
    return (t == TMR_MAX) ? TMR_MAX : t + 16'd1;
  endfunction

  // Fresh attempt: timers and power-good filter cleared
  function automatic void start_attempt(input logic [4:0] v, input pdsvn_pkg::mode_e m);
    p_mode      = m;
    p_target    = v;
    p_reached   = '0;
    p_attempt   = '0;
    p_pg_good   = 1'b0;
    p_pg_raw    = 1'b0;
    p_pg_stable = '0;
  endfunction

  // One tick of the negotiator; returns the status word it yields
  function automatic pdsvn_pkg::out_word_t advance_negotiator(input pdsvn_pkg::in_word_t w);
    pdsvn_pkg::out_word_t r;
    logic                 bad;
    logic                 save;
    logic                 started;
    bad     = 1'b0;
    save    = 1'b0;
    started = 1'b0;
    if (w.opcode == pdsvn_pkg::OP_SET) begin
      if (is_pd_level(w.requested_volts)) begin
        start_attempt(w.requested_volts, pdsvn_pkg::MODE_NEG);
        started = 1'b1;
      end else begin
        bad = 1'b1;
      end
    end else if (w.opcode == pdsvn_pkg::OP_AUTO) begin
      p_try = '0;
      start_attempt(STEP_DOWN[4:0], pdsvn_pkg::MODE_AUTO);
      started = 1'b1;
    end
    if (!started) begin
      p_attempt   = sat_inc16(p_attempt);
      p_pg_stable = sat_inc16(p_pg_stable);
    end
    // debounce
    if (w.pg_pin_low != p_pg_raw) begin
      p_pg_stable = '0;
      p_pg_raw    = w.pg_pin_low;
    end
    if (p_pg_stable >= r_debounce) p_pg_good = w.pg_pin_low;
    // negotiation progress
    if (p_mode == pdsvn_pkg::MODE_NEG || p_mode == pdsvn_pkg::MODE_AUTO) begin
      if (p_pg_good) begin
        p_mode    = pdsvn_pkg::MODE_OK;
        p_reached = p_target;
        save      = 1'b1;
      end else if (p_attempt >= r_timeout) begin
        if (p_mode == pdsvn_pkg::MODE_NEG) begin
          p_mode    = pdsvn_pkg::MODE_FAIL;
          p_reached = '0;
        end else begin
          p_try = p_try + 3'd1;
          if (p_try >= pdsvn_pkg::LEVEL_COUNT) begin
            p_mode    = pdsvn_pkg::MODE_FAIL;
            p_reached = '0;
          end else begin
            start_attempt(STEP_DOWN[p_try*5 +: 5], pdsvn_pkg::MODE_AUTO);
          end
        end
      end
    end
    r.negotiation_state = p_mode;
    r.target_volts      = p_target;
    r.negotiated_volts  = p_reached;
    r.cfg_pin_one       = (p_target == 5'd5);
    r.cfg_pin_two       = (p_target == 5'd15 || p_target == 5'd20);
    r.cfg_pin_three     = (p_target == 5'd12 || p_target == 5'd15);
    r.power_good        = p_pg_good;
    r.bad_request       = bad;
    r.save_pulse        = save;
    return r;
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      err_count++;
    end
  endfunction

  // Word driver: predicts at acceptance, then offers the next pending word
  always @(posedge clk_i) begin : word_driver
    logic took;
    took = in_valid_i && in_ready_o;
    if (took) begin
      expected_status_q.push_back(advance_negotiator(in_data_i));
      tick_q.delete(0);
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || took) begin
      if (tick_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= tick_q[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and receiver back-pressure
  always @(posedge clk_i) begin : result_monitor
    pdsvn_pkg::out_word_t exp_w;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t ns: unexpected status word, expected none, got %h", $time, out_data_o);
        err_count++;
      end else begin
        exp_w = expected_status_q.pop_front();
        check_field("negotiation_state", 8'(exp_w.negotiation_state),
                    8'(out_data_o.negotiation_state));
        check_field("target_volts", 8'(exp_w.target_volts), 8'(out_data_o.target_volts));
        check_field("negotiated_volts", 8'(exp_w.negotiated_volts),
                    8'(out_data_o.negotiated_volts));
        check_field("cfg_pin_one", 8'(exp_w.cfg_pin_one), 8'(out_data_o.cfg_pin_one));
        check_field("cfg_pin_two", 8'(exp_w.cfg_pin_two), 8'(out_data_o.cfg_pin_two));
        check_field("cfg_pin_three", 8'(exp_w.cfg_pin_three), 8'(out_data_o.cfg_pin_three));
        check_field("power_good", 8'(exp_w.power_good), 8'(out_data_o.power_good));
        check_field("bad_request", 8'(exp_w.bad_request), 8'(out_data_o.bad_request));
        check_field("save_pulse", 8'(exp_w.save_pulse), 8'(out_data_o.save_pulse));
      end
    end
    // long hold-off when stimulus asks for one
    if (hold_served != hold_requests) begin
      hold_served++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic queue_word(input logic [1:0] op, input logic [4:0] volts, input logic raw);
    pdsvn_pkg::in_word_t w;
    w.opcode          = op;
    w.requested_volts = volts;
    w.pg_pin_low      = raw;
    tick_q.push_back(w);
  endtask

  task automatic wait_drained();
    while (tick_q.size() != 0 || expected_status_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [pdsvn_pkg::CFG_IDX_W-1:0] idx,
                           input logic [pdsvn_pkg::CFG_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      pdsvn_pkg::CFG_TIMEOUT:  r_timeout  = val;
      pdsvn_pkg::CFG_DEBOUNCE: r_debounce = val;
      pdsvn_pkg::CFG_POWER_ON: begin
        r_power_on = val[4:0];
        start_attempt(is_pd_level(r_power_on) ? r_power_on : pdsvn_pkg::DEFAULT_LEVEL,
                      pdsvn_pkg::MODE_NEG);
        p_try = '0;
      end
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [15:0] to, input logic [15:0] db,
                            input logic [4:0] pov);
    write_reg(pdsvn_pkg::CFG_TIMEOUT, to);
    write_reg(pdsvn_pkg::CFG_DEBOUNCE, db);
    write_reg(pdsvn_pkg::CFG_POWER_ON, {11'd0, pov});
  endtask

  // Mostly commands followed by tick runs with a held power-good level, plus noise
  task automatic queue_random(input int unsigned n);
    int unsigned k;
    int unsigned pick;
    int unsigned run;
    int unsigned max_run;
    logic        lvl;
    logic [4:0]  v;
    k       = 0;
    max_run = (r_timeout > 16'd20) ? 124 : 6 * r_timeout + 4;
    while (k < n) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        if ($urandom_range(2) == 0) begin
          queue_word(pdsvn_pkg::OP_AUTO, 5'($urandom_range(31)), 1'($urandom_range(1)));
        end else begin
          queue_word(pdsvn_pkg::OP_SET, STEP_DOWN[$urandom_range(4)*5 +: 5],
                     1'($urandom_range(1)));
        end
        k++;
        run = $urandom_range(1, max_run);
        if (run > n - k) run = n - k;
        lvl = 1'($urandom_range(1));
        repeat (run) begin
          if ($urandom_range(9) == 0) lvl = ~lvl;
          queue_word(($urandom_range(7) == 0) ? OP_SPARE : pdsvn_pkg::OP_TICK,
                     5'($urandom_range(31)), lvl);
          k++;
        end
      end else if (pick < 80) begin
        // unsupported voltage request
        v = 5'($urandom_range(31));
        while (is_pd_level(v)) v = 5'($urandom_range(31));
        queue_word(pdsvn_pkg::OP_SET, v, 1'($urandom_range(1)));
        k++;
      end else begin
        queue_word(2'($urandom_range(3)), 5'($urandom_range(31)), 1'($urandom_range(1)));
        k++;
      end
    end
  endtask

  initial begin : stimulus
    r_timeout  = pdsvn_pkg::TIMEOUT_RESET;
    r_debounce = pdsvn_pkg::DEBOUNCE_RESET;
    r_power_on = pdsvn_pkg::DEFAULT_LEVEL;
    start_attempt(pdsvn_pkg::DEFAULT_LEVEL, pdsvn_pkg::MODE_NEG);
    p_try = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    snd_idle_pct = 38;
    rcv_idle_pct = 50;
    // state right after reset: 12 V single negotiation under way
    repeat (3) queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b0);
    wait_drained();

    // directed: shortest timeout, no debounce
    set_config(16'd1, 16'd0, 5'd9);
    queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b0);     // single attempt times out
    queue_word(pdsvn_pkg::OP_SET, 5'd5, 1'b1);      // immediate success at 5 V
    queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b1);     // settled, nothing moves
    queue_word(pdsvn_pkg::OP_SET, 5'd7, 1'b0);      // unsupported levels
    queue_word(pdsvn_pkg::OP_SET, 5'd31, 1'b0);
    queue_word(pdsvn_pkg::OP_SET, 5'd0, 1'b0);
    queue_word(pdsvn_pkg::OP_SET, 5'd15, 1'b0);
    queue_word(pdsvn_pkg::OP_SET, 5'd12, 1'b0);
    queue_word(pdsvn_pkg::OP_SET, 5'd20, 1'b0);
    queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b0);
    queue_word(pdsvn_pkg::OP_AUTO, 5'd0, 1'b0);     // step down through every level to failure
    repeat (5) queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b0);
    queue_word(OP_SPARE, 5'd31, 1'b1);              // spare opcode behaves as a tick
    queue_word(pdsvn_pkg::OP_AUTO, 5'd10, 1'b1);    // auto succeeds at 20 V
    queue_word(pdsvn_pkg::OP_AUTO, 5'd21, 1'b0);
    queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b0);
    queue_word(pdsvn_pkg::OP_TICK, 5'd0, 1'b1);     // succeeds one step down
    wait_drained();

    set_config(16'd1, 16'd0, 5'd5);
    queue_random(100);
    wait_drained();
    set_config(16'd5, 16'd2, 5'd20);
    queue_random(100);
    wait_drained();
    set_config(16'd12, 16'd3, 5'd7);     // power-on level not supported
    queue_random(100);
    wait_drained();

    snd_idle_pct = 50;
    rcv_idle_pct = 38;
    set_config(16'hFFFF, 16'd0, 5'd15);
    queue_random(100);
    wait_drained();
    set_config(16'd3, 16'hFFFF, 5'd9);
    queue_random(100);
    wait_drained();
    set_config(16'd8, 16'd6, 5'd0);
    queue_random(100);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    // receiver stalls while the sender keeps offering
    set_config(16'd20, 16'd1, 5'd31);
    hold_requests++;
    queue_random(100);
    wait_drained();
    set_config(16'($urandom_range(1, 30)), 16'($urandom_range(0, 10)),
               5'($urandom_range(31)));
    queue_random(100);
    wait_drained();

    repeat (8) @(posedge clk_i);
    if (err_count == 0 && expected_status_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/pdsvn_pkg.sv
rtl/pdsvn_debounce.sv
rtl/pdsvn_ctrl.sv
rtl/pd_sink_voltage_negotiator.sv
test/tb_pd_sink_voltage_negotiator.sv
